// ===== design/bba_pkg.sv =====
// shared types and constants for the buddy block allocator
// used by bba_ctrl, bba_datapath and buddy_block_allocator_core
package bba_pkg;

  localparam int ARENA_BYTES = 4096;
  localparam int LEVELS      = $clog2(ARENA_BYTES);
  localparam int OFF_W       = LEVELS;
  localparam int SIZE_W      = LEVELS + 1;
  localparam int IDX_W       = LEVELS + 1;
  localparam int DEPTH_W     = $clog2(LEVELS + 1);
  localparam int NODES       = 2 * ARENA_BYTES;

  typedef enum logic [1:0] {
    ND_UNUSED = 2'd0,
    ND_FREE   = 2'd1,
    ND_USED   = 2'd2,
    ND_SPLIT  = 2'd3
  } node_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    RST_DONE   = 2'd0,
    RST_NOFIT  = 2'd1,
    RST_BADOFF = 2'd2
  } resp_e;

  // movement of the current node index
  typedef enum logic [2:0] {
    IX_HOLD = 3'd0,
    IX_LEFT = 3'd1,
    IX_OFF  = 3'd2,
    IX_UP   = 3'd3,
    IX_NEXT = 3'd4
  } idx_op_e;

  typedef enum logic [1:0] {
    WS_SELF   = 2'd0,
    WS_RIGHT  = 2'd1,
    WS_PARENT = 2'd2
  } wr_sel_e;

  typedef enum logic [2:0] {
    RS_NONE   = 3'd0,
    RS_GRANT  = 3'd1,
    RS_NOFIT  = 3'd2,
    RS_BADOFF = 3'd3,
    RS_OK     = 3'd4
  } res_op_e;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    rd_sib;
    logic    wr;
    wr_sel_e wr_sel;
    node_e   wr_val;
    idx_op_e idx_op;
    res_op_e res_op;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    node_e node_st;
    node_e root_st;
    logic  is_root;
    logic  idx_odd;
    logic  at_want;
    logic  last_split;
    logic  oversize;
    logic  req_free;
    logic  off_aligned;
    logic  out_free;
  } dp_stat_t;

endpackage

// ===== design/bba_datapath.sv =====
// datapath of the buddy block allocator: node store, walk index and result registers
// depends on bba_pkg
module bba_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bba_pkg::cmd_t                cmd_i,
  output bba_pkg::dp_stat_t            stat_o,
  input  logic                         req_type_i,
  input  logic [bba_pkg::SIZE_W-1:0]   alloc_size_i,
  input  logic [bba_pkg::OFF_W-1:0]    block_offset_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [bba_pkg::OFF_W-1:0]    granted_offset_o,
  output logic [bba_pkg::SIZE_W-1:0]   granted_size_o
);
  import bba_pkg::*;

  localparam logic [DEPTH_W-1:0] TOP_BIT = DEPTH_W'(LEVELS - 1);
  localparam logic [DEPTH_W-1:0] LEV     = DEPTH_W'(LEVELS);

  logic [1:0]         mem [NODES];
  logic [1:0]         rd_q;
  logic               rd_root_q;
  node_e              root_q;
  logic               req_q;
  logic               over_q;
  logic [DEPTH_W-1:0] wdepth_q;
  logic [OFF_W-1:0]   off_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [1:0]         res_status_q;
  logic [OFF_W-1:0]   res_off_q;
  logic [SIZE_W-1:0]  res_size_q;
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [OFF_W-1:0]   out_off_q;
  logic [SIZE_W-1:0]  out_size_q;

  logic [DEPTH_W-1:0]     k;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [SIZE_W-1:0]      span;
  logic [IDX_W+OFF_W-1:0] shifted;

  // ceiling log2 of the request, zero treated as one
  always_comb begin
    k = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (alloc_size_i > (SIZE_W'(1) << i)) k = DEPTH_W'(i + 1);
    end
  end

  always_comb begin
    idx_d   = idx_q;
    depth_d = depth_q;
    case (cmd_i.idx_op)
      IX_LEFT: begin
        idx_d   = {idx_q[IDX_W-2:0], 1'b0};
        depth_d = depth_q + 1'b1;
      end
      IX_OFF: begin
        idx_d   = {idx_q[IDX_W-2:0], off_q[TOP_BIT - depth_q]};
        depth_d = depth_q + 1'b1;
      end
      IX_UP: begin
        idx_d   = idx_q >> 1;
        depth_d = depth_q - 1'b1;
      end
      IX_NEXT: idx_d = idx_q + 1'b1;
      default: ;
    endcase
    if (cmd_i.load) begin
      idx_d   = IDX_W'(1);
      depth_d = '0;
    end
  end

  assign rd_addr = cmd_i.rd_sib ? (idx_q ^ IDX_W'(1)) : idx_q;

  always_comb begin
    case (cmd_i.wr_sel)
      WS_RIGHT:  wr_addr = {idx_q[IDX_W-2:0], 1'b1};
      WS_PARENT: wr_addr = idx_q >> 1;
      default:   wr_addr = idx_q;
    endcase
  end

  assign span    = SIZE_W'(1) << (LEV - depth_q);
  assign shifted = {idx_q, {OFF_W{1'b0}}} >> depth_q;

  // node store, the root lives in its own register
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_addr != IDX_W'(1)) mem[wr_addr] <= cmd_i.wr_val;
    if (cmd_i.rd) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= ND_FREE;
      rd_root_q   <= 1'b0;
      idx_q       <= IDX_W'(1);
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr && wr_addr == IDX_W'(1)) root_q <= cmd_i.wr_val;
      if (cmd_i.rd) rd_root_q <= (rd_addr == IDX_W'(1));
      idx_q   <= idx_d;
      depth_q <= depth_d;
      if (cmd_i.publish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      over_q   <= (alloc_size_i > SIZE_W'(ARENA_BYTES));
      wdepth_q <= LEV - k;
      off_q    <= block_offset_i;
    end
    case (cmd_i.res_op)
      RS_GRANT: begin
        res_status_q <= RST_DONE;
        res_off_q    <= shifted[OFF_W-1:0];
        res_size_q   <= span;
      end
      RS_NOFIT: begin
        res_status_q <= RST_NOFIT;
        res_off_q    <= '0;
        res_size_q   <= '0;
      end
      RS_BADOFF: begin
        res_status_q <= RST_BADOFF;
        res_off_q    <= '0;
        res_size_q   <= '0;
      end
      RS_OK: begin
        res_status_q <= RST_DONE;
        res_off_q    <= '0;
        res_size_q   <= '0;
      end
      default: ;
    endcase
    if (cmd_i.publish) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_size_q   <= res_size_q;
    end
  end

  always_comb begin
    stat_o.node_st     = rd_root_q ? root_q : node_e'(rd_q);
    stat_o.root_st     = root_q;
    stat_o.is_root     = (idx_q == IDX_W'(1));
    stat_o.idx_odd     = idx_q[0];
    stat_o.at_want     = (depth_q == wdepth_q);
    stat_o.last_split  = (depth_q + 1'b1 == wdepth_q);
    stat_o.oversize    = over_q;
    stat_o.req_free    = (req_q == REQ_FREE);
    stat_o.off_aligned = ((off_q & (span[OFF_W-1:0] - 1'b1)) == '0);
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_off_q;
  assign granted_size_o   = out_size_q;

endmodule

// ===== design/bba_ctrl.sv =====
// controller of the buddy block allocator: search, split, lookup and merge sequencing
// depends on bba_pkg
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bba_pkg::dp_stat_t stat_i,
  output bba_pkg::cmd_t     cmd_o
);
  import bba_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_START = 13'b0000000000010,
    S_A_RD  = 13'b0000000000100,
    S_A_EV  = 13'b0000000001000,
    S_A_UP  = 13'b0000000010000,
    S_A_SPL = 13'b0000000100000,
    S_A_SIB = 13'b0000001000000,
    S_A_USE = 13'b0000010000000,
    S_F_RD  = 13'b0000100000000,
    S_F_EV  = 13'b0001000000000,
    S_F_MRD = 13'b0010000000000,
    S_F_MEV = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (!stat_i.req_free) begin
          if (stat_i.oversize) begin
            cmd_o.res_op = RS_NOFIT;
            state_d      = S_DONE;
          end else begin
            cmd_o.rd = 1'b1;
            state_d  = S_A_EV;
          end
        end else if (stat_i.root_st != ND_SPLIT) begin
          // unsplit root: any free releases the whole arena
          cmd_o.wr     = 1'b1;
          cmd_o.wr_val = ND_FREE;
          cmd_o.res_op = RS_OK;
          state_d      = S_DONE;
        end else begin
          cmd_o.idx_op = IX_OFF;
          state_d      = S_F_RD;
        end
      end
      S_A_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_A_EV;
      end
      S_A_EV: begin
        if (stat_i.node_st == ND_FREE) begin
          state_d = stat_i.at_want ? S_A_USE : S_A_SPL;
        end else if (stat_i.node_st == ND_SPLIT && !stat_i.at_want) begin
          cmd_o.idx_op = IX_LEFT;
          state_d      = S_A_RD;
        end else begin
          state_d = S_A_UP;
        end
      end
      S_A_UP: begin
        // climb past right children, then step to the next sibling
        if (stat_i.is_root) begin
          cmd_o.res_op = RS_NOFIT;
          state_d      = S_DONE;
        end else if (stat_i.idx_odd) begin
          cmd_o.idx_op = IX_UP;
        end else begin
          cmd_o.idx_op = IX_NEXT;
          state_d      = S_A_RD;
        end
      end
      S_A_SPL: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wr_val = ND_SPLIT;
        state_d      = S_A_SIB;
      end
      S_A_SIB: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wr_sel = WS_RIGHT;
        cmd_o.wr_val = ND_FREE;
        cmd_o.idx_op = IX_LEFT;
        state_d      = stat_i.last_split ? S_A_USE : S_A_SPL;
      end
      S_A_USE: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wr_val = ND_USED;
        cmd_o.res_op = RS_GRANT;
        state_d      = S_DONE;
      end
      S_F_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_F_EV;
      end
      S_F_EV: begin
        if (stat_i.node_st == ND_SPLIT) begin
          cmd_o.idx_op = IX_OFF;
          state_d      = S_F_RD;
        end else if (stat_i.off_aligned) begin
          cmd_o.wr     = 1'b1;
          cmd_o.wr_val = ND_FREE;
          state_d      = S_F_MRD;
        end else begin
          cmd_o.res_op = RS_BADOFF;
          state_d      = S_DONE;
        end
      end
      S_F_MRD: begin
        if (stat_i.is_root) begin
          cmd_o.res_op = RS_OK;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sib = 1'b1;
          state_d      = S_F_MEV;
        end
      end
      S_F_MEV: begin
        // free buddy: the parent becomes one free block
        if (stat_i.node_st == ND_FREE) begin
          cmd_o.wr     = 1'b1;
          cmd_o.wr_sel = WS_PARENT;
          cmd_o.wr_val = ND_FREE;
          cmd_o.idx_op = IX_UP;
          state_d      = S_F_MRD;
        end else begin
          cmd_o.res_op = RS_OK;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== design/buddy_block_allocator_core.sv =====
// buddy block allocator over a 4096 byte arena, one request at a time
// input item: req_type_i, alloc_size_i, block_offset_i; handshake in_valid_i / in_stall_o
// result item: status_o, granted_offset_o, granted_size_o; handshake out_valid_o / out_stall_i
// an allocate rounds the size up to a power of two and takes the lowest-address free
// block of that size, splitting larger free blocks; a free releases the block starting
// at the offset and merges free buddies upwards
// the walk runs over one node store with one read and one write port: an allocate
// descends level by level and splits down to the wanted size, an oversize allocate
// is refused without a walk, and a failing or fragmented allocate also climbs back
// past the nodes it passes; a free with an unsplit root releases the arena without a
// walk, otherwise it descends to the block at the offset, then merges while the buddy
// is free, at most up to the root
// only one item is in flight; a new item is taken the cycle after the previous result has
// been loaded into the output register, which holds it while out_stall_i is high
// after reset the arena is one free block; no clearing pass is needed
// depends on bba_pkg, bba_ctrl and bba_datapath
module buddy_block_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [bba_pkg::SIZE_W-1:0] alloc_size_i,
  input  logic [bba_pkg::OFF_W-1:0]  block_offset_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [bba_pkg::OFF_W-1:0]  granted_offset_o,
  output logic [bba_pkg::SIZE_W-1:0] granted_size_o
);
  import bba_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bba_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (req_type_i),
    .alloc_size_i     (alloc_size_i),
    .block_offset_i   (block_offset_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o),
    .granted_size_o   (granted_size_o)
  );

endmodule
